FILE: rtl/mff_pkg.sv
// ----------------------------------------------------------------------------
// mff_pkg
// Shared types, codes and loop-threshold tables for the flood forward filter.
// ----------------------------------------------------------------------------
package mff_pkg;

    localparam int MAX_HOPS     = 63;
    localparam int HASH_LEN_MAX = 3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_ROLE        = 3'd0,
        CFG_FORWARD_DISABLED = 3'd1,
        CFG_FLOOD_HOP_LIMIT  = 3'd2,
        CFG_LOOP_MODE        = 3'd3,
        CFG_CLIENT_REPEAT_ON = 3'd4,
        CFG_SELF_HASH_PREFIX = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ROLE_REPEATER = 2'd0,
        ROLE_CHAT     = 2'd1,
        ROLE_OTHER    = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        LOOP_OFF      = 2'd0,
        LOOP_MINIMAL  = 2'd1,
        LOOP_MODERATE = 2'd2,
        LOOP_STRICT   = 2'd3
    } loop_mode_t;

    typedef enum logic [2:0] {
        REASON_FORWARD  = 3'd0,
        REASON_ROLE     = 3'd1,
        REASON_DISABLED = 3'd2,
        REASON_HOP_LIMIT = 3'd3,
        REASON_LOOP     = 3'd4
    } reason_t;

    typedef struct packed {
        logic    allow_forward;
        logic    loop_found;
        reason_t decision_reason;
    } result_t;

    localparam logic [2:0] THR_MINIMAL  [4] = '{3'd0, 3'd4, 3'd2, 3'd1};
    localparam logic [2:0] THR_MODERATE [4] = '{3'd0, 3'd2, 3'd1, 3'd1};
    localparam logic [2:0] THR_STRICT   [4] = '{3'd0, 3'd1, 3'd1, 3'd1};

    // Self-match count needed to call a loop, by mode and hash length
    function automatic logic [2:0] loop_threshold(input logic [1:0] mode,
                                                  input logic [1:0] hash_len);
        logic [2:0] thr;
        thr = 3'd0;
        case (loop_mode_t'(mode))
            LOOP_MINIMAL:  thr = THR_MINIMAL[hash_len];
            LOOP_MODERATE: thr = THR_MODERATE[hash_len];
            LOOP_STRICT:   thr = THR_STRICT[hash_len];
            default:       thr = 3'd0;
        endcase
        return thr;
    endfunction

endpackage

FILE: rtl/mesh_flood_forward_filter_unit.sv
// A last_item decision is registered in out_reg, or in skid_reg if out_reg stays full.
// One input transaction per cycle while s_ready is high; path entries match on arrival.
// A two-deep result buffer (output register plus skid) sets when s_ready drops:
// only while the skid holds a result, i.e. after two results wait unread.
// Reset: synchronous, active low; clears packet state, config registers and the result
// buffer valid flags to their defaults (result data is not reset). No clearing pass.
// ----------------------------------------------------------------------------
// mesh_flood_forward_filter_unit
// Streams a packet header and its path entries, counts own-prefix matches and
// issues the forward/drop decision on the packet's last item.
// ----------------------------------------------------------------------------
module mesh_flood_forward_filter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mff_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mff_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_first_item,
    input  logic                              s_last_item,
    input  logic                              s_flood_route,
    input  logic [2:0]                        s_path_stride,
    input  logic                              s_snr_present,
    input  logic [5:0]                        s_hop_count,
    input  logic                              s_entry_valid,
    input  logic [23:0]                       s_path_entry,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_allow_forward,
    output logic                              m_loop_found,
    output logic [2:0]                        m_decision_reason
);

    // configuration
    logic [1:0]  node_role_reg;
    logic        forward_disabled_reg;
    logic [7:0]  flood_hop_limit_reg;
    logic [1:0]  loop_mode_reg;
    logic        client_repeat_on_reg;
    logic [23:0] self_hash_prefix_reg;

    // packet state
    logic [5:0]  match_count_reg,  match_count_next;
    logic [5:0]  entries_seen_reg, entries_seen_next;
    logic        latched_flood_reg,    latched_flood_next;
    logic [1:0]  latched_hash_len_reg, latched_hash_len_next;
    logic        latched_size_ok_reg,  latched_size_ok_next;
    logic [5:0]  latched_hops_reg,     latched_hops_next;

    // result buffer
    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    mff_pkg::result_t   out_reg, out_next;
    mff_pkg::result_t   skid_reg, skid_next;
    mff_pkg::result_t   result;

    logic        in_accept, push, pop;
    logic        hdr_ok;
    logic [1:0]  hdr_len;
    logic [5:0]  mc_cur, es_cur;
    logic        take_entry, prefix_hit;
    logic [23:0] len_mask;
    logic [2:0]  thr;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;
    assign push      = in_accept && s_last_item;
    assign pop       = out_valid_reg && m_ready;

    assign m_valid           = out_valid_reg;
    assign m_allow_forward   = out_reg.allow_forward;
    assign m_loop_found      = out_reg.loop_found;
    assign m_decision_reason = out_reg.decision_reason;

    // header decode and entry match
    always_comb begin
        hdr_ok  = (s_path_stride >= 3'd1) && (s_path_stride <= 3'(mff_pkg::HASH_LEN_MAX));
        hdr_len = s_path_stride[1:0];
        if (s_snr_present) begin
            if (s_path_stride < 3'd2) begin
                hdr_ok = 1'b0;
            end else begin
                hdr_len = 2'(s_path_stride - 3'd1);
            end
        end
        if (!hdr_ok) begin
            hdr_len = 2'd0;
        end

        if (s_first_item) begin
            latched_flood_next    = s_flood_route;
            latched_hash_len_next = hdr_len;
            latched_size_ok_next  = hdr_ok;
            latched_hops_next     = ({2'b00, s_hop_count} > 8'(mff_pkg::MAX_HOPS)) ?
                                    6'(mff_pkg::MAX_HOPS) : s_hop_count;
            mc_cur = 6'd0;
            es_cur = 6'd0;
        end else begin
            latched_flood_next    = latched_flood_reg;
            latched_hash_len_next = latched_hash_len_reg;
            latched_size_ok_next  = latched_size_ok_reg;
            latched_hops_next     = latched_hops_reg;
            mc_cur = match_count_reg;
            es_cur = entries_seen_reg;
        end

        case (latched_hash_len_next)
            2'd1:    len_mask = 24'h0000FF;
            2'd2:    len_mask = 24'h00FFFF;
            2'd3:    len_mask = 24'hFFFFFF;
            default: len_mask = 24'h000000;
        endcase
        prefix_hit = ((s_path_entry ^ self_hash_prefix_reg) & len_mask) == 24'h0;

        take_entry        = s_entry_valid && (es_cur < latched_hops_next);
        entries_seen_next = take_entry ? es_cur + 6'd1 : es_cur;
        match_count_next  = (take_entry && latched_size_ok_next && prefix_hit &&
                             (mc_cur != 6'd63)) ? mc_cur + 6'd1 : mc_cur;
    end

    // decision
    always_comb begin
        thr = mff_pkg::loop_threshold(loop_mode_reg, latched_hash_len_next);
        result.allow_forward   = 1'b0;
        result.loop_found      = 1'b0;
        result.decision_reason = mff_pkg::REASON_ROLE;
        if (node_role_reg == mff_pkg::ROLE_REPEATER) begin
            if (forward_disabled_reg) begin
                result.decision_reason = mff_pkg::REASON_DISABLED;
            end else if (latched_flood_next &&
                         ({2'b00, latched_hops_next} >= flood_hop_limit_reg)) begin
                result.decision_reason = mff_pkg::REASON_HOP_LIMIT;
            end else if (latched_flood_next && (loop_mode_reg != mff_pkg::LOOP_OFF) &&
                         latched_size_ok_next && (match_count_next >= {3'b000, thr})) begin
                result.loop_found      = 1'b1;
                result.decision_reason = mff_pkg::REASON_LOOP;
            end else begin
                result.allow_forward   = 1'b1;
                result.decision_reason = mff_pkg::REASON_FORWARD;
            end
        end else if (client_repeat_on_reg && (node_role_reg == mff_pkg::ROLE_CHAT)) begin
            result.allow_forward   = 1'b1;
            result.decision_reason = mff_pkg::REASON_FORWARD;
        end
    end

    // result buffer steering
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_role_reg        <= mff_pkg::ROLE_OTHER;
            forward_disabled_reg <= 1'b0;
            flood_hop_limit_reg  <= 8'd64;
            loop_mode_reg        <= mff_pkg::LOOP_OFF;
            client_repeat_on_reg <= 1'b0;
            self_hash_prefix_reg <= 24'h0;
            match_count_reg      <= 6'd0;
            entries_seen_reg     <= 6'd0;
            latched_flood_reg    <= 1'b0;
            latched_hash_len_reg <= 2'd0;
            latched_size_ok_reg  <= 1'b0;
            latched_hops_reg     <= 6'd0;
            out_valid_reg        <= 1'b0;
            skid_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (mff_pkg::cfg_index_t'(cfg_index))
                    mff_pkg::CFG_NODE_ROLE:        node_role_reg        <= cfg_data[1:0];
                    mff_pkg::CFG_FORWARD_DISABLED: forward_disabled_reg <= cfg_data[0];
                    mff_pkg::CFG_FLOOD_HOP_LIMIT:  flood_hop_limit_reg  <= cfg_data[7:0];
                    mff_pkg::CFG_LOOP_MODE:        loop_mode_reg        <= cfg_data[1:0];
                    mff_pkg::CFG_CLIENT_REPEAT_ON: client_repeat_on_reg <= cfg_data[0];
                    mff_pkg::CFG_SELF_HASH_PREFIX: self_hash_prefix_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                match_count_reg      <= match_count_next;
                entries_seen_reg     <= entries_seen_next;
                latched_flood_reg    <= latched_flood_next;
                latched_hash_len_reg <= latched_hash_len_next;
                latched_size_ok_reg  <= latched_size_ok_next;
                latched_hops_reg     <= latched_hops_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

`ifndef SYNTH
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_entries_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_seen_reg <= latched_hops_reg)
        else $error("entries taken exceed latched hop count");

    a_matches_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        match_count_reg <= entries_seen_reg)
        else $error("match count exceeds entries taken");

    a_loop_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.loop_found |->
            !out_reg.allow_forward && (out_reg.decision_reason == mff_pkg::REASON_LOOP))
        else $error("loop result not reported as a loop drop");

    a_allow_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
            (out_reg.allow_forward == (out_reg.decision_reason == mff_pkg::REASON_FORWARD)))
        else $error("allow flag and reason disagree");
`endif

endmodule
